>>> rtl/core/tss_pkg.sv
// Shared constants, codes and control/status types of the timed segment sequencer.
package tss_pkg;

  // Segment list depth and the widths that follow from it
  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int REQ_W  = 2;
  localparam int TIME_W = 32;
  localparam int LEFT_W = TIME_W + 1;
  localparam int IDX_W  = 6;
  localparam int PROG_W = 17;
  localparam int FRAC_W = PROG_W - 1;
  localparam int ENTRY_W = TIME_W + LEFT_W;

  // Divider runs one quotient bit per cycle
  localparam int DIV_STEPS = FRAC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [PROG_W-1:0] FULL_PROGRESS = PROG_W'(1) << FRAC_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_PUSH  = 2'd1,
    REQ_CALL  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_DIV,
    S_PEMIT,
    S_CALL
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic push;           // append a segment unless full
    logic clear;          // empty the list
    logic tick_start;     // latch tick amount, read current entry
    logic tick_complete;  // write back, emit complete word, advance, read next
    logic tick_partial;   // write back, load divider
    logic div_step;       // one quotient bit
    logic part_emit;      // emit partial progress word
    logic call_emit;      // emit complete word for complete-all, advance
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic can_tick;   // tick would do work
    logic can_call;   // a segment remains
    logic left_neg;   // current segment overran
    logic more;       // a segment follows the current one
    logic div_done;   // quotient ready
    logic out_free;   // output register can take a word
  } status_t;

endpackage

>>> rtl/core/tss_ram.sv
// Generic single write, single read RAM with registered read data.
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/tss_ctrl.sv
// Controller state machine of the timed segment sequencer.
module tss_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [tss_pkg::REQ_W-1:0]      in_req_type,
  output logic                           in_stall,
  input  tss_pkg::status_t               status,
  output tss_pkg::cmd_t                  cmd
);
  import tss_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_req_type)
            REQ_TICK: begin
              if (status.can_tick) begin
                cmd.tick_start = 1'b1;
                state_nxt      = S_TICK;
              end
            end
            REQ_PUSH: begin
              cmd.push = 1'b1;
            end
            REQ_CALL: begin
              if (status.can_call) begin
                state_nxt = S_CALL;
              end
            end
            REQ_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_TICK: begin
        // Overrun: report complete and walk on; else compute the fraction
        if (status.left_neg) begin
          if (status.out_free) begin
            cmd.tick_complete = 1'b1;
            if (!status.more) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          cmd.tick_partial = 1'b1;
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_PEMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_PEMIT: begin
        if (status.out_free) begin
          cmd.part_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CALL: begin
        if (status.out_free) begin
          cmd.call_emit = 1'b1;
          if (!status.more) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/tss_dp.sv
// Datapath: segment store, index and count, tick arithmetic, divider, output word.
module tss_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic [tss_pkg::TIME_W-1:0]     in_tick_amount,
  input  logic [tss_pkg::TIME_W-1:0]     in_segment_duration,
  input  tss_pkg::cmd_t                  cmd,
  output tss_pkg::status_t               status,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tss_pkg::IDX_W-1:0]      out_segment_index,
  output logic [tss_pkg::PROG_W-1:0]     out_progress,
  output logic                           out_last,
  output logic                           out_sequence_done
);
  import tss_pkg::*;

  logic                paused_r;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TIME_W-1:0]   pass_r;
  logic [TIME_W-1:0]   rem_r;
  logic [FRAC_W-1:0]   quo_r;
  logic                full_r;
  logic [STEP_W-1:0]   step_r;

  logic                out_valid_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [PROG_W-1:0]   out_prog_r;
  logic                out_last_r;
  logic                out_done_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [TIME_W-1:0]   rd_dur;
  logic [LEFT_W-1:0]   rd_left;
  logic [LEFT_W-1:0]   left;
  logic [LEFT_W-1:0]   excess;
  logic [TIME_W-1:0]   num;
  logic [CNT_W-1:0]    idx_inc;
  logic                more;
  logic                full_list;
  logic [TIME_W:0]     rem_sh;
  logic                rem_ge;
  logic                out_free;
  logic                emit;
  logic [PROG_W-1:0]   emit_prog;
  logic                emit_last;
  logic                emit_done;

  // Segment store: duration and time left per entry
  tss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_dur  = ram_rdata[ENTRY_W-1:LEFT_W];
  assign rd_left = ram_rdata[LEFT_W-1:0];

  // Tick arithmetic on the current entry
  assign left      = rd_left - {1'b0, pass_r};
  assign excess    = LEFT_W'(0) - left;
  assign num       = rd_dur - left[TIME_W-1:0];
  assign idx_inc   = idx_r + CNT_W'(1);
  assign more      = (idx_inc < cnt_r);
  assign full_list = (cnt_r == CNT_W'(DEPTH));

  // Store write and read selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[ADDR_W-1:0];
    ram_wdata = {rd_dur, left};
    if (cmd.push && !full_list) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r[ADDR_W-1:0];
      ram_wdata = {in_segment_duration, 1'b0, in_segment_duration};
    end else if (cmd.tick_complete || cmd.tick_partial) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = cmd.tick_start || (cmd.tick_complete && more);
  assign ram_raddr = cmd.tick_start ? idx_r[ADDR_W-1:0] : idx_inc[ADDR_W-1:0];

  // Pause register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r <= 1'b0;
    end else if (cfg_wr_en) begin
      paused_r <= cfg_wr_data;
    end
  end

  // Index and count
  always_comb begin
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      idx_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.push && !full_list) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.tick_complete || cmd.call_emit) begin
      idx_nxt = idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Time still to spend: latch on start, carry the excess on overrun
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      pass_r <= in_tick_amount;
    end else if (cmd.tick_complete) begin
      pass_r <= excess[TIME_W-1:0];
    end
  end

  // Restoring divider: (num << 16) / dur, one bit per cycle
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, rd_dur});

  always_ff @(posedge clk) begin
    if (cmd.tick_partial) begin
      rem_r  <= num;
      quo_r  <= '0;
      full_r <= (num == rd_dur);
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= TIME_W'(rem_sh - {1'b0, rd_dur});
      end else begin
        rem_r <= rem_sh[TIME_W-1:0];
      end
      quo_r <= {quo_r[FRAC_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.tick_partial) begin
      step_r <= STEP_W'(DIV_STEPS);
    end else if (cmd.div_step) begin
      step_r <= step_r - STEP_W'(1);
    end
  end

  // Output word register
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = cmd.tick_complete || cmd.call_emit || cmd.part_emit;
  assign emit_prog = cmd.part_emit ? (full_r ? FULL_PROGRESS : {1'b0, quo_r})
                                   : FULL_PROGRESS;
  assign emit_last = cmd.part_emit || !more;
  assign emit_done = cmd.part_emit ? (idx_r >= cnt_r) : !more;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r  <= IDX_W'(idx_r[ADDR_W-1:0]);
      out_prog_r <= emit_prog;
      out_last_r <= emit_last;
      out_done_r <= emit_done;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_index = out_idx_r;
  assign out_progress      = out_prog_r;
  assign out_last          = out_last_r;
  assign out_sequence_done = out_done_r;

  // Status to the controller
  always_comb begin
    status.can_tick = !paused_r && (in_tick_amount != '0) && (idx_r < cnt_r);
    status.can_call = (idx_r < cnt_r);
    status.left_neg = left[LEFT_W-1];
    status.more     = more;
    status.div_done = (step_r == '0);
    status.out_free = out_free;
  end

endmodule

>>> rtl/core/timed_segment_sequencer_unit.sv
// Top level of the timed segment sequencer: controller, datapath and checks.
//
// Holds up to 16 timed segments. Input words carry a request type: tick,
// push segment, complete all, or clear. Output words report a segment index,
// its progress in Q1.16 (65536 = complete), a last flag on the final word of
// a request and a sequence-done flag. cfg_wr_en/cfg_wr_data set the pause bit.
// Push and clear are done on acceptance and produce no word. Complete-all is
// accepted in the idle state, then emits one word per cycle while the output
// is free. A tick is accepted in the idle state, where the store read is
// issued; then each overrun segment emits a complete word and reads the next
// entry. A tick that ends inside a segment writes that entry back, loads the
// bit-serial divider (16 quotient bits and a finishing check) and emits a
// partial word once the divider is done. The divider and the single store
// read port set the pace of a tick. in_stall is high whenever a request is
// still being worked on.
// A result waits in the output register while out_stall is high; the
// controller holds in its emitting state until that register frees up.
// After reset the list is empty, the index is zero and the block is unpaused.
module timed_segment_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tss_pkg::REQ_W-1:0]      in_req_type,
  input  logic [tss_pkg::TIME_W-1:0]     in_tick_amount,
  input  logic [tss_pkg::TIME_W-1:0]     in_segment_duration,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tss_pkg::IDX_W-1:0]      out_segment_index,
  output logic [tss_pkg::PROG_W-1:0]     out_progress,
  output logic                           out_last,
  output logic                           out_sequence_done
);
  import tss_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing
  tss_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // Store, arithmetic and output word
  tss_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_tick_amount      (in_tick_amount),
    .in_segment_duration (in_segment_duration),
    .cmd                 (cmd),
    .status              (status),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_segment_index   (out_segment_index),
    .out_progress        (out_progress),
    .out_last            (out_last),
    .out_sequence_done   (out_sequence_done)
  );

  // A tick's complete word is only issued for an overrun segment
  a_complete_on_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_complete |-> status.left_neg)
    else $error("complete word issued without overrun");

  // The partial word only goes out once the divider has finished
  a_partial_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.part_emit |-> status.div_done)
    else $error("partial word issued before divider finished");

  // A word that ends the sequence also ends its request
  a_done_implies_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sequence_done) |-> out_last)
    else $error("sequence done without last");

  // Emitting never happens while the output register is held
  a_no_emit_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |->
      !(cmd.tick_complete || cmd.call_emit || cmd.part_emit))
    else $error("word emitted into a held output register");

endmodule
